// File: rtl/core/ofb_pkg.sv
package ofb_pkg;

  localparam int unsigned COLUMNS    = 128;
  localparam int unsigned PAGES      = 8;
  localparam int unsigned STORE_SIZE = COLUMNS * PAGES;
  localparam int unsigned PAGE_LEN   = COLUMNS + 3;

  localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ADDR_W = $clog2(STORE_SIZE);
  localparam int unsigned OFF_W  = $clog2(PAGE_LEN);

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LO_CMD    = 8'h00;
  localparam logic [7:0] COL_HI_CMD    = 8'h10;

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_FILL    = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_EMIT,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic       pixel_on;
    logic [7:0] fill_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic              is_data;
    logic [7:0]        cmd_byte;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic              frame_end;
  } refr_t;

endpackage

// File: rtl/core/ofb_store.sv
module ofb_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ofb_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      re_i,
  input  logic [ofb_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem_q [ofb_pkg::STORE_SIZE];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/ofb_refresh.sv
module ofb_refresh (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  output ofb_pkg::refr_t refr_o
);

  logic [ofb_pkg::PAGE_W-1:0] page_q, page_d;
  logic [ofb_pkg::OFF_W-1:0]  off_q, off_d;
  logic                       page_last, off_last;

  assign page_last = (page_q == ofb_pkg::PAGE_W'(ofb_pkg::PAGES - 1));
  assign off_last  = (off_q == ofb_pkg::OFF_W'(ofb_pkg::PAGE_LEN - 1));

  always_comb begin
    page_d = page_q;
    off_d  = off_q;
    if (step_i) begin
      if (off_last) begin
        off_d  = '0;
        page_d = page_last ? '0 : page_q + 1'b1;
      end else begin
        off_d = off_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      off_q  <= '0;
    end else begin
      page_q <= page_d;
      off_q  <= off_d;
    end
  end

  always_comb begin
    refr_o.page      = page_q;
    refr_o.col       = ofb_pkg::COL_W'(off_q - ofb_pkg::OFF_W'(3));
    refr_o.is_data   = (off_q > ofb_pkg::OFF_W'(2));
    refr_o.frame_end = page_last && off_last;
    case (off_q)
      ofb_pkg::OFF_W'(0): refr_o.cmd_byte = 8'(ofb_pkg::PAGE_CMD_BASE + 8'(page_q));
      ofb_pkg::OFF_W'(1): refr_o.cmd_byte = ofb_pkg::COL_LO_CMD;
      ofb_pkg::OFF_W'(2): refr_o.cmd_byte = ofb_pkg::COL_HI_CMD;
      default:            refr_o.cmd_byte = '0;
    endcase
  end

endmodule

// File: rtl/core/oled_page_frame_buffer.sv
// oled_page_frame_buffer: page-mode monochrome frame buffer for a small panel
//
// input channel (in_valid_i / in_ready_o / in_item_i) carries three kinds of item:
//   draw    - set or clear one pixel, no result; off-panel coordinates are ignored
//   fill    - write fill_byte to every entry, no result
//   refresh - emit the next byte of the panel refresh sequence as one result
// output channel (out_valid_o / out_ready_i / out_item_o) carries refresh bytes,
// marked command or data, with frame_end on the last byte of the frame.
//
// the store is one synchronous ram with a registered read port; items are taken
// one at a time. a draw reads the entry, then writes it back; an off-panel draw
// is dropped when it is taken; a refresh reads, then loads the output register; and
// a fill writes one entry per cycle through the single write port.
// a refresh result is loaded in the emit state, once the output register is free.
// after reset a clearing pass writes zero to all 1024 entries,
// during which no item is accepted.
// a stalled receiver holds the result in the output register; draws and fills
// still go ahead, and the next refresh waits until that register is free.
module oled_page_frame_buffer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ofb_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ofb_pkg::out_item_t  out_item_o
);

  ofb_pkg::state_e state_q, state_d;

  logic [ofb_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic [7:0]                 fill_q, fill_d;
  logic [ofb_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]                 mask_q, mask_d;
  logic                       set_q, set_d;
  ofb_pkg::refr_t             pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;
  ofb_pkg::out_item_t         out_q, out_d;

  logic                       in_acc, load_out, cnt_last, draw_ok;
  logic                       mem_we, mem_re, refr_step;
  logic [ofb_pkg::ADDR_W-1:0] mem_waddr, mem_raddr, draw_addr, refr_addr;
  logic [7:0]                 mem_wdata, mem_rdata;
  logic [ofb_pkg::PAGE_W-1:0] draw_page;
  ofb_pkg::refr_t             refr;

  assign in_acc   = in_valid_i && in_ready_o;
  assign load_out = (state_q == ofb_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign cnt_last = (cnt_q == ofb_pkg::ADDR_W'(ofb_pkg::STORE_SIZE - 1));

  assign draw_ok = ({1'b0, in_item_i.x} < 9'(ofb_pkg::COLUMNS)) &&
                   ({1'b0, in_item_i.y} < 9'(ofb_pkg::PAGES * 8));
  assign draw_page = ofb_pkg::PAGE_W'(ofb_pkg::PAGES - 1) -
                     ofb_pkg::PAGE_W'(in_item_i.y >> 3);
  assign draw_addr = ofb_pkg::ADDR_W'(ofb_pkg::ADDR_W'(in_item_i.x) *
                                      ofb_pkg::ADDR_W'(ofb_pkg::PAGES)) +
                     ofb_pkg::ADDR_W'(draw_page);
  assign refr_addr = ofb_pkg::ADDR_W'(ofb_pkg::ADDR_W'(refr.col) *
                                      ofb_pkg::ADDR_W'(ofb_pkg::PAGES)) +
                     ofb_pkg::ADDR_W'(refr.page);

  ofb_refresh u_refresh (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (refr_step),
    .refr_o (refr)
  );

  ofb_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ofb_pkg::ST_CLEAR: if (cnt_last) state_d = ofb_pkg::ST_IDLE;
      ofb_pkg::ST_FILL:  if (cnt_last) state_d = ofb_pkg::ST_IDLE;
      ofb_pkg::ST_DRAW:  state_d = ofb_pkg::ST_IDLE;
      ofb_pkg::ST_EMIT:  if (load_out) state_d = ofb_pkg::ST_IDLE;
      ofb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.cmd)
            ofb_pkg::CMD_DRAW:    if (draw_ok) state_d = ofb_pkg::ST_DRAW;
            ofb_pkg::CMD_FILL:    state_d = ofb_pkg::ST_FILL;
            ofb_pkg::CMD_REFRESH: state_d = ofb_pkg::ST_EMIT;
            default:              state_d = ofb_pkg::ST_IDLE;
          endcase
        end
      end
      default: state_d = ofb_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = fill_q;
    mem_re     = 1'b0;
    mem_raddr  = draw_addr;
    refr_step  = 1'b0;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    addr_d     = addr_q;
    mask_d     = mask_q;
    set_d      = set_q;
    pend_d     = pend_q;
    case (state_q)
      ofb_pkg::ST_CLEAR, ofb_pkg::ST_FILL: begin
        mem_we = 1'b1;
        cnt_d  = cnt_last ? '0 : cnt_q + 1'b1;
      end
      ofb_pkg::ST_DRAW: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = set_q ? (mem_rdata | mask_q) : (mem_rdata & ~mask_q);
      end
      ofb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_item_i.cmd)
            ofb_pkg::CMD_DRAW: begin
              mem_re = draw_ok;
              addr_d = draw_addr;
              mask_d = 8'h80 >> in_item_i.y[2:0];
              set_d  = in_item_i.pixel_on;
            end
            ofb_pkg::CMD_FILL: begin
              fill_d = in_item_i.fill_byte;
              cnt_d  = '0;
            end
            ofb_pkg::CMD_REFRESH: begin
              mem_re    = refr.is_data;
              mem_raddr = refr_addr;
              refr_step = 1'b1;
              pend_d    = refr;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_d.out_byte  = pend_q.is_data ? mem_rdata : pend_q.cmd_byte;
      out_d.is_data   = pend_q.is_data;
      out_d.frame_end = pend_q.frame_end;
      out_valid_d     = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ofb_pkg::ST_CLEAR;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    mask_q <= mask_d;
    set_q  <= set_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_refresh_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.cmd == ofb_pkg::CMD_REFRESH) |=> state_q == ofb_pkg::ST_EMIT)
    else $error("refresh item did not enter emit");

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("loaded result not presented");

  a_frame_end_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end |-> out_item_o.is_data)
    else $error("frame end on a command byte");

  a_fill_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ofb_pkg::ST_FILL) && cnt_last |=> state_q == ofb_pkg::ST_IDLE)
    else $error("fill did not finish at the last entry");

endmodule
